/* rtl/core/deq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque package
// Sizes, operation and status codes, the request bundle passed from the
// pointer controller to the datapath, and the circular index helper.
// ----------------------------------------------------------------------------
package deq_pkg;

	// Queue geometry
	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int SUM_W   = IDX_W + 1;

	// Payload widths
	localparam int VALUE_W = 32;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;

	// Result word: front, back, count, status, padded to whole bytes
	localparam int RES_BITS = 2 * VALUE_W + CNT_W + STAT_W;
	localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;
	localparam int FRONT_LO = 0;
	localparam int BACK_LO  = VALUE_W;
	localparam int CNT_LO   = 2 * VALUE_W;
	localparam int STAT_LO  = 2 * VALUE_W + CNT_W;

	// Operation codes (six and seven behave as peek)
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;
	localparam logic [OP_W-1:0] OP_PEEK       = 3'd5;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// One transaction's worth of memory access and result bookkeeping
	typedef struct packed {
		logic                  wr_en;
		logic [IDX_W-1:0]      wr_addr;
		logic [VALUE_W-1:0]    wr_data;
		logic [IDX_W-1:0]      rd_front;
		logic [IDX_W-1:0]      rd_back;
		logic [CNT_W-1:0]      count;
		logic                  empty;
		logic [STAT_W-1:0]     status;
	} deq_req_t;

	// (a + b) mod DEPTH for a, b below DEPTH
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/core/double_ended_queue_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of signed 32-bit values in a circular RAM buffer. Each
// transaction pushes, pops, clears or peeks and returns both end entries,
// the entry count and a status.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata (low bit up)                        tuser
//  s_axis    in   value[31:0]                               opcode[2:0]
//  m_axis    out  front[31:0] back[31:0] count[4:0]
//                 status[1:0] pad                           -
//
//  An item is taken every cycle while results are drained; the pointer
//  update is done in the accept cycle, so the next item may follow at once.
//  A result passes the RAM read register and then the output register.
//  A stalled output holds the read stage, and drops s_axis_tready once
//  that stage is full. Reset empties the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [deq_pkg::VALUE_W-1:0] s_axis_tdata,  // value
	input  wire logic [deq_pkg::OP_W-1:0]    s_axis_tuser,  // opcode
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic      [deq_pkg::RES_W-1:0]   m_axis_tdata   // front, back, count, status
);
	import deq_pkg::*;

	deq_req_t           req;
	logic               accept;
	logic               out_load;
	logic [VALUE_W-1:0] rd_front;
	logic [VALUE_W-1:0] rd_back;
	logic [VALUE_W-1:0] front_val;
	logic [VALUE_W-1:0] back_val;
	logic [RES_W-1:0]   res_d;

	// Read stage
	logic               valid_s1;
	logic               fwd_front_s1;
	logic               fwd_back_s1;
	logic [VALUE_W-1:0] wdata_s1;
	logic               empty_s1;
	logic [CNT_W-1:0]   count_s1;
	logic [STAT_W-1:0]  status_s1;

	// Output register
	logic               out_valid_q;
	logic [RES_W-1:0]   out_data_q;

	// Handshake
	assign out_load      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_load;
	assign accept        = s_axis_tvalid && s_axis_tready;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.opcode (s_axis_tuser),
		.value  (s_axis_tdata),
		.req    (req)
	);

	deq_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (accept && req.wr_en),
		.wr_addr   (req.wr_addr),
		.wr_data   (req.wr_data),
		.rd_en     (accept),
		.rd_addr_a (req.rd_front),
		.rd_addr_b (req.rd_back),
		.rd_data_a (rd_front),
		.rd_data_b (rd_back)
	);

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	// Read stage payload; forward the value written in the same cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_front_s1 <= req.wr_en && (req.wr_addr == req.rd_front);
			fwd_back_s1  <= req.wr_en && (req.wr_addr == req.rd_back);
			wdata_s1     <= req.wr_data;
			empty_s1     <= req.empty;
			count_s1     <= req.count;
			status_s1    <= req.status;
		end
	end

	// Result assembly
	assign front_val = empty_s1 ? '0 : (fwd_front_s1 ? wdata_s1 : rd_front);
	assign back_val  = empty_s1 ? '0 : (fwd_back_s1 ? wdata_s1 : rd_back);

	always_comb begin
		res_d = '0;
		res_d[FRONT_LO +: VALUE_W] = front_val;
		res_d[BACK_LO +: VALUE_W]  = back_val;
		res_d[CNT_LO +: CNT_W]     = count_s1;
		res_d[STAT_LO +: STAT_W]   = status_s1;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s1) begin
			out_data_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Checks
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_load |-> !accept ##1 valid_s1)
		else $error("read stage lost while output stalled");

	a_empty_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[STAT_LO +: STAT_W] == ST_EMPTY)
		|-> m_axis_tdata[CNT_LO +: CNT_W] == '0)
		else $error("empty refusal with entries held");

	a_full_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[STAT_LO +: STAT_W] == ST_FULL)
		|-> m_axis_tdata[CNT_LO +: CNT_W] == CNT_W'(DEPTH))
		else $error("full refusal below capacity");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[CNT_LO +: CNT_W] == '0)
		|-> m_axis_tdata[FRONT_LO +: VALUE_W] == '0
			&& m_axis_tdata[BACK_LO +: VALUE_W] == '0)
		else $error("empty queue reports non-zero ends");

endmodule
`default_nettype wire

/* rtl/core/deq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with registered read data. A read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]         rd_data_a,
	output logic      [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read ports, held while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/deq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque pointer controller
// Holds the front slot and the fill count, decodes the operation, works out
// the slot to write and the slots of the new front and back entries.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [deq_pkg::OP_W-1:0]    opcode,
	input  wire logic [deq_pkg::VALUE_W-1:0] value,
	output deq_pkg::deq_req_t                req
);
	import deq_pkg::*;

	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] front_nx;
	logic [CNT_W-1:0] count_nx;
	logic [CNT_W-1:0] last_off;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic             full;
	logic             empty;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = wrap_add(front_q, IDX_W'(1));

	// Operation decode
	always_comb begin
		front_nx    = front_q;
		count_nx    = count_q;
		req.wr_en   = 1'b0;
		req.wr_addr = front_dec;
		req.wr_data = value;
		req.status  = ST_OK;
		unique case (opcode)
			OP_PUSH_FRONT: begin
				if (full) begin
					req.status = ST_FULL;
				end else begin
					front_nx  = front_dec;
					count_nx  = count_q + 1'b1;
					req.wr_en = 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				req.wr_addr = wrap_add(front_q, count_q[IDX_W-1:0]);
				if (full) begin
					req.status = ST_FULL;
				end else begin
					count_nx  = count_q + 1'b1;
					req.wr_en = 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					req.status = ST_EMPTY;
				end else begin
					front_nx = front_inc;
					count_nx = count_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					req.status = ST_EMPTY;
				end else begin
					count_nx = count_q - 1'b1;
				end
			end
			OP_CLEAR: begin
				front_nx = '0;
				count_nx = '0;
			end
			default: begin
			end
		endcase

		// Read slots of the entries at either end after the step
		last_off     = count_nx - 1'b1;
		req.rd_front = front_nx;
		req.rd_back  = wrap_add(front_nx, last_off[IDX_W-1:0]);
		req.count    = count_nx;
		req.empty    = (count_nx == '0);
	end

	// Pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_nx;
			count_q <= count_nx;
		end
	end

endmodule
`default_nettype wire
